>>> rtl/shs_pkg.sv
// Shared types, constants and the round-constant table of the SHA-256 stream hasher.
package shs_pkg;

  // Source of the byte that is shifted into the message window
  typedef enum logic [1:0] {
    BSEL_MSG  = 2'd0,
    BSEL_PAD  = 2'd1,
    BSEL_ZERO = 2'd2,
    BSEL_LEN  = 2'd3
  } byte_sel_t;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [1:0] PART_LAST  = 2'd3;

  // Word 0 is the most significant word (H0 / a)
  typedef logic [0:7][31:0] chain_t;

  localparam chain_t IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic       shift_byte;   // shift one byte into the message window
    byte_sel_t  byte_sel;
    logic       add_len;      // message byte: bump the bit count
    logic       init_work;    // working vars <= chain
    logic       round_en;     // one compression round
    logic [5:0] round_idx;
    logic       fold;         // chain += working vars
    logic       load_digest;  // chain -> output buffer, chain <= IV
  } shs_cmd_t;

  typedef struct packed {
    logic obuf_busy;
  } shs_status_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/sha256_stream_hasher_unit.sv
// Top level of the SHA-256 stream hasher: controller plus datapath.
// Throughput: one item per cycle while a block fills; each 64th byte starts the rounds
//   and the fold, during which input stalls; the pace is set by the single round unit.
// End of message: the pad bytes fill the block and it is compressed, an extra block follows
//   when the length does not fit, then the digest waits while the previous digest drains;
//   parts leave one per cycle while out_stall is low.
// Reset (rst, synchronous, active high): chaining words to the initial hash, counters empty.
module sha256_stream_hasher_unit
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input channel: one item per handshake
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  // output channel: one digest quarter per item
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest_part,
  output logic [1:0]  part_index,
  output logic        last_part
);

  shs_cmd_t    cmd;
  shs_status_t status;

  // Controller: counts bytes into the 64-byte block, sequences the padding
  // bytes (0x80, zeros, big-endian bit count), runs 64 rounds per block and
  // hands the finished chain to the digest buffer. Input stalls whenever the
  // controller is not taking message bytes.
  shs_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .status         (status),
    .cmd            (cmd)
  );

  // Datapath: byte-wide shift into a 512-bit window that doubles as the
  // message schedule, one round per cycle, chain fold, and a 256-bit digest
  // buffer so a new message can start while the last digest drains.
  shs_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_part (digest_part),
    .part_index  (part_index),
    .last_part   (last_part)
  );

endmodule

>>> rtl/shs_datapath.sv
// Datapath: message window, compression round, chaining words, bit count, digest buffer.
module shs_datapath
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  shs_cmd_t    cmd,
  input  logic [7:0]  data_byte,
  output shs_status_t status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest_part,
  output logic [1:0]  part_index,
  output logic        last_part
);

  chain_t        chain;
  chain_t        work;
  logic [511:0]  msg;         // W[t] in the top word
  logic [63:0]   bit_length;
  logic [255:0]  obuf;
  logic [1:0]    part_cnt;

  logic [7:0]    byte_in;
  logic [31:0]   w0, w1, w9, w14, w_new;
  logic [31:0]   sum0, sum1, ch, maj, t1, t2, a_new, e_new;
  logic          out_take;

  always_comb begin
    case (cmd.byte_sel)
      BSEL_MSG:  byte_in = data_byte;
      BSEL_PAD:  byte_in = PAD_BYTE;
      BSEL_ZERO: byte_in = 8'h00;
      BSEL_LEN:  byte_in = bit_length[63:56];
      default:   byte_in = 8'h00;
    endcase
  end

  // message schedule over a sliding 16-word window
  assign w0  = msg[511:480];
  assign w1  = msg[479:448];
  assign w9  = msg[223:192];
  assign w14 = msg[63:32];
  assign w_new = ({w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ {10'd0, w14[31:10]})
               + w9
               + ({w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'd0, w1[31:3]})
               + w0;

  // one compression round
  assign sum1 = {work[4][5:0], work[4][31:6]} ^ {work[4][10:0], work[4][31:11]}
              ^ {work[4][24:0], work[4][31:25]};
  assign ch   = (work[4] & work[5]) ^ (~work[4] & work[6]);
  assign t1   = work[7] + sum1 + ch + round_k(cmd.round_idx) + w0;
  assign sum0 = {work[0][1:0], work[0][31:2]} ^ {work[0][12:0], work[0][31:13]}
              ^ {work[0][21:0], work[0][31:22]};
  assign maj  = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
  assign t2   = sum0 + maj;
  assign a_new = t1 + t2;
  assign e_new = work[3] + t1;

  assign out_take = out_valid && !out_stall;

  // control-bearing state
  always_ff @(posedge clk) begin
    if (rst) begin
      chain      <= IV;
      bit_length <= 64'd0;
      out_valid  <= 1'b0;
      part_cnt   <= 2'd0;
    end else begin
      if (cmd.add_len) begin
        bit_length <= bit_length + 64'd8;
      end else if (cmd.shift_byte && (cmd.byte_sel == BSEL_LEN)) begin
        bit_length <= {bit_length[55:0], 8'h00};   // back to zero after eight length bytes
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + work[i];
        end
      end else if (cmd.load_digest) begin
        chain <= IV;
      end
      if (cmd.load_digest) begin
        out_valid <= 1'b1;
        part_cnt  <= 2'd0;
      end else if (out_take) begin
        if (part_cnt == PART_LAST) begin
          out_valid <= 1'b0;
        end
        part_cnt <= part_cnt + 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      msg <= {msg[503:0], byte_in};
    end else if (cmd.round_en) begin
      msg <= {msg[479:0], w_new};
    end
    if (cmd.init_work) begin
      work <= chain;
    end else if (cmd.round_en) begin
      work <= {a_new, work[0], work[1], work[2], e_new, work[4], work[5], work[6]};
    end
    if (cmd.load_digest) begin
      obuf <= chain;
    end else if (out_take) begin
      obuf <= {obuf[191:0], 64'd0};
    end
  end

  assign status.obuf_busy = out_valid;
  assign digest_part      = obuf[255:192];
  assign part_index       = part_cnt;
  assign last_part        = (part_cnt == PART_LAST);

endmodule

>>> rtl/shs_ctrl.sv
// Controller: byte intake, padding sequence, round counter and digest hand-off.
module shs_ctrl
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        byte_valid,
  input  logic        end_of_message,
  input  shs_status_t status,
  output shs_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ROUND  = 5'b00010,
    ST_FOLD   = 5'b00100,
    ST_PAD    = 5'b01000,
    ST_DIGEST = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [5:0] fill, fill_next;
  logic [5:0] round_cnt, round_cnt_next;
  logic       pad_active, pad_active_next;   // message closed, padding under way
  logic       pad_marked, pad_marked_next;   // 0x80 already written
  logic       pad_extra, pad_extra_next;     // zeros to end of block, length goes in next one
  logic       final_blk, final_blk_next;     // block being compressed carries the length
  logic       in_take;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    round_cnt_next  = round_cnt;
    pad_active_next = pad_active;
    pad_marked_next = pad_marked;
    pad_extra_next  = pad_extra;
    final_blk_next  = final_blk;
    cmd             = '0;
    cmd.byte_sel    = BSEL_MSG;
    cmd.round_idx   = round_cnt;

    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (byte_valid) begin
            cmd.shift_byte = 1'b1;
            cmd.add_len    = 1'b1;
            fill_next      = fill + 6'd1;
            if (fill == BLOCK_LAST) begin
              cmd.init_work   = 1'b1;
              state_next      = ST_ROUND;
              pad_active_next = end_of_message;
            end else if (end_of_message) begin
              state_next      = ST_PAD;
              pad_active_next = 1'b1;
            end
          end else if (end_of_message) begin
            state_next      = ST_PAD;
            pad_active_next = 1'b1;
          end
        end
      end
      ST_PAD: begin
        cmd.shift_byte = 1'b1;
        fill_next      = fill + 6'd1;
        if (!pad_marked) begin
          cmd.byte_sel    = BSEL_PAD;
          pad_marked_next = 1'b1;
          pad_extra_next  = (fill >= LEN_POS);
        end else if (pad_extra || (fill < LEN_POS)) begin
          cmd.byte_sel = BSEL_ZERO;
        end else begin
          cmd.byte_sel = BSEL_LEN;
        end
        if (fill == BLOCK_LAST) begin
          cmd.init_work  = 1'b1;
          state_next     = ST_ROUND;
          final_blk_next = (cmd.byte_sel == BSEL_LEN);
          // next block, if any, carries zeros and then the length
          pad_extra_next = 1'b0;
        end
      end
      ST_ROUND: begin
        cmd.round_en   = 1'b1;
        round_cnt_next = round_cnt + 6'd1;
        if (round_cnt == ROUND_LAST) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (final_blk) begin
          state_next = ST_DIGEST;
        end else if (pad_active) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIGEST: begin
        if (!status.obuf_busy) begin
          cmd.load_digest = 1'b1;
          pad_active_next = 1'b0;
          pad_marked_next = 1'b0;
          pad_extra_next  = 1'b0;
          final_blk_next  = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= 6'd0;
      round_cnt  <= 6'd0;
      pad_active <= 1'b0;
      pad_marked <= 1'b0;
      pad_extra  <= 1'b0;
      final_blk  <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      round_cnt  <= round_cnt_next;
      pad_active <= pad_active_next;
      pad_marked <= pad_marked_next;
      pad_extra  <= pad_extra_next;
      final_blk  <= final_blk_next;
    end
  end

endmodule

>>> rtl/shs_checker.sv
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
module shs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        end_of_message,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] digest_part,
  input logic [1:0]  part_index,
  input logic        last_part
);

  // digest parts leave in order, with no gap inside one digest
  a_part_seq: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && (part_index != 2'd3)) |=>
      (out_valid && (part_index == $past(part_index) + 2'd1)))
    else $error("digest part sequence broken");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_part == (part_index == 2'd3)))
    else $error("last_part does not match part_index");

  // closing a message always leaves idle (padding, or rounds when its byte fills a block), so input stalls next cycle
  a_eom_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && end_of_message) |=> in_stall)
    else $error("input not stalled after end of message");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(digest_part) && $stable(part_index)))
    else $error("stalled digest item changed");

endmodule

bind sha256_stream_hasher_unit shs_checker u_shs_checker (.*);
